[src/sleep_delta_queue_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sleep delta queue
// Shared helpers for concurrent checks, clocked on clk with rst_n as reset.
// ----------------------------------------------------------------------------
`ifndef SLEEP_DELTA_QUEUE_CORE_ASSERT_SVH
`define SLEEP_DELTA_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication.
`define SDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sdq_pkg.sv]
// ----------------------------------------------------------------------------
// Sleep delta queue package
// Shared constants, codes and the stored entry type.
// ----------------------------------------------------------------------------
package sdq_pkg;

    localparam int MAX_SLEEPERS_DEF = 16;
    localparam int TID_W            = 8;
    localparam int DELTA_W          = 16;

    localparam logic CMD_SLEEP = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic STATUS_WOKEN  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [TID_W-1:0]   thread;
        logic [DELTA_W-1:0] delta;
    } entry_t;

endpackage

[src/sdq_req_if.sv]
// ----------------------------------------------------------------------------
// Sleep delta queue request channel
// Carries sleep and tick commands with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdq_req_if;

    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [sdq_pkg::TID_W-1:0]    thread_id;
    logic [sdq_pkg::DELTA_W-1:0]  sleep_ticks;

    modport source (output valid, cmd, thread_id, sleep_ticks, input ready);
    modport sink   (input valid, cmd, thread_id, sleep_ticks, output ready);

endinterface

[src/sdq_rsp_if.sv]
// ----------------------------------------------------------------------------
// Sleep delta queue result channel
// Carries woken or rejected thread ids with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sdq_rsp_if;

    logic                       valid;
    logic                       ready;
    logic [sdq_pkg::TID_W-1:0]  woken_thread;
    logic                       status;
    logic                       last;

    modport source (output valid, woken_thread, status, last, input ready);
    modport sink   (input valid, woken_thread, status, last, output ready);

endinterface

[src/sdq_ram.sv]
// ----------------------------------------------------------------------------
// Sleep delta queue entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sdq_ram #(
    parameter int DEPTH = sdq_pkg::MAX_SLEEPERS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  sdq_pkg::entry_t   wdata,
    input  logic [AW-1:0]     raddr,
    output sdq_pkg::entry_t   rdata
);

    sdq_pkg::entry_t mem [DEPTH];
    sdq_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/sleep_delta_queue_core.sv]
// Sequencing: a sleep holds the request channel while it walks the entries, moves
// entries back and inserts; a tick checks the head entry, then decrements it or
// wakes each zero-delta thread in turn, and a reject sends one result; wakes and
// rejects also wait while the result channel stalls. One request is handled at a
// time; the entry memory has a registered read.
// Reset: asynchronous, clears the queue to empty; the memory holds no reset.
// ----------------------------------------------------------------------------
// Sleep delta queue core
// Delta-list timer queue of thread ids kept as a ring in one entry memory.
// ----------------------------------------------------------------------------
module sleep_delta_queue_core #(
    parameter int MAX_SLEEPERS = sdq_pkg::MAX_SLEEPERS_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    sdq_req_if.sink   req,
    sdq_rsp_if.source rsp
);

    `include "sleep_delta_queue_core_assert.svh"

    localparam int AW  = (MAX_SLEEPERS > 1) ? $clog2(MAX_SLEEPERS) : 1;
    localparam int AW1 = AW + 1;
    localparam int CW  = $clog2(MAX_SLEEPERS + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_WALK   = 7'b0000010,
        ST_SHIFT  = 7'b0000100,
        ST_INSERT = 7'b0001000,
        ST_TCHK   = 7'b0010000,
        ST_TNEXT  = 7'b0100000,
        ST_REJ    = 7'b1000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [AW-1:0]                   head_reg, head_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [CW-1:0]                   pos_reg, pos_next;
    logic [CW-1:0]                   k_reg, k_next;
    logic [sdq_pkg::DELTA_W-1:0]     rest_reg, rest_next;
    logic [sdq_pkg::TID_W-1:0]       tid_reg, tid_next;
    logic [sdq_pkg::TID_W-1:0]       pend_reg, pend_next;

    logic                            out_valid_reg, out_valid_next;
    logic [sdq_pkg::TID_W-1:0]       out_thread_reg, out_thread_next;
    logic                            out_status_reg, out_status_next;
    logic                            out_last_reg, out_last_next;

    logic                            we;
    logic [AW-1:0]                   waddr, raddr;
    sdq_pkg::entry_t                 wdata, rdata;
    logic                            slot_free;
    logic                            more;

    // Ring position of logical slot x.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] x);
        logic [AW1-1:0] s;
        s = {1'b0, hd} + AW1'(x);
        if (s >= AW1'(MAX_SLEEPERS))
        begin
            s = s - AW1'(MAX_SLEEPERS);
        end
        return s[AW-1:0];
    endfunction

    sdq_ram #(
        .DEPTH (MAX_SLEEPERS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign slot_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign more      = (pos_reg < count_reg) && (rdata.delta == '0);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        k_next          = k_reg;
        rest_next       = rest_reg;
        tid_next        = tid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_thread_next = out_thread_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        we              = 1'b0;
        waddr           = phys(head_reg, pos_reg);
        wdata           = rdata;
        raddr           = phys(head_reg, pos_reg);

        case (state_reg)
            ST_IDLE:
            begin
                raddr = head_reg;
                if (req.valid)
                begin
                    pos_next = '0;
                    if (req.cmd == sdq_pkg::CMD_SLEEP)
                    begin
                        tid_next  = req.thread_id;
                        rest_next = (req.sleep_ticks == '0) ? sdq_pkg::DELTA_W'(1)
                                                             : req.sleep_ticks;
                        if (count_reg == CW'(MAX_SLEEPERS))
                        begin
                            state_next = ST_REJ;
                        end
                        else
                        begin
                            state_next = ST_WALK;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        state_next = ST_TCHK;
                    end
                end
            end
            ST_WALK:
            begin
                if ((pos_reg < count_reg) && (rest_reg >= rdata.delta))
                begin
                    rest_next = rest_reg - rdata.delta;
                    pos_next  = pos_reg + CW'(1);
                    raddr     = phys(head_reg, pos_reg + CW'(1));
                end
                else if (pos_reg == count_reg)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    k_next     = count_reg;
                    raddr      = phys(head_reg, count_reg - CW'(1));
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                // Move slot k-1 to slot k; the old occupant of the insert slot
                // gives up the new sleeper's remaining delay.
                we    = 1'b1;
                waddr = phys(head_reg, k_reg);
                if ((k_reg - CW'(1)) == pos_reg)
                begin
                    wdata.delta = rdata.delta - rest_reg;
                    state_next  = ST_INSERT;
                end
                else
                begin
                    raddr  = phys(head_reg, k_reg - CW'(2));
                    k_next = k_reg - CW'(1);
                end
            end
            ST_INSERT:
            begin
                we           = 1'b1;
                wdata.thread = tid_reg;
                wdata.delta  = rest_reg;
                count_next   = count_reg + CW'(1);
                state_next   = ST_IDLE;
            end
            ST_TCHK:
            begin
                if (rdata.delta > sdq_pkg::DELTA_W'(1))
                begin
                    we          = 1'b1;
                    waddr       = head_reg;
                    wdata.delta = rdata.delta - sdq_pkg::DELTA_W'(1);
                    state_next  = ST_IDLE;
                end
                else
                begin
                    pend_next  = rdata.thread;
                    pos_next   = CW'(1);
                    raddr      = phys(head_reg, CW'(1));
                    state_next = ST_TNEXT;
                end
            end
            ST_TNEXT:
            begin
                // The pending thread goes out once we know whether another
                // zero-delta entry follows it.
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_thread_next = pend_reg;
                    out_status_next = sdq_pkg::STATUS_WOKEN;
                    out_last_next   = !more;
                    if (more)
                    begin
                        pend_next = rdata.thread;
                        pos_next  = pos_reg + CW'(1);
                        raddr     = phys(head_reg, pos_reg + CW'(1));
                    end
                    else
                    begin
                        head_next  = phys(head_reg, pos_reg);
                        count_next = count_reg - pos_reg;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REJ:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_thread_next = tid_reg;
                    out_status_next = sdq_pkg::STATUS_REJECT;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        k_reg          <= k_next;
        rest_reg       <= rest_next;
        tid_reg        <= tid_next;
        pend_reg       <= pend_next;
        out_thread_reg <= out_thread_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.woken_thread = out_thread_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.last         = out_last_reg;

    `SDQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_SLEEPERS), "queue count overflow")
    `SDQ_ASSERT_NEXT(a_insert_grows, state_reg == ST_INSERT, count_reg == $past(count_reg) + CW'(1), "insert did not grow queue")
    `SDQ_ASSERT_NEXT(a_wake_shrinks, (state_reg == ST_TNEXT) && slot_free && !more, count_reg < $past(count_reg), "wake did not shrink queue")
    `SDQ_ASSERT_NOW(a_reject_last, rsp.valid && (rsp.status == sdq_pkg::STATUS_REJECT), rsp.last, "reject result not marked last")

endmodule

[dv/sleep_delta_queue_core_tb.sv]
// ----------------------------------------------------------------------------
// Sleep delta queue core testbench
// Drives sleep and tick requests with random idling on both channels and
// compares each woken or rejected thread with a delta-list model of the queue.
// ----------------------------------------------------------------------------
module sleep_delta_queue_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = sdq_pkg::MAX_SLEEPERS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 200;

    typedef struct packed {
        logic                        cmd;
        logic [sdq_pkg::TID_W-1:0]   tid;
        logic [sdq_pkg::DELTA_W-1:0] ticks;
    } request_t;

    typedef struct packed {
        logic [sdq_pkg::TID_W-1:0] thread;
        logic                      status;
        logic                      last;
    } wake_t;

    // Directed row: has_fixed marks a row whose single result is typed in.
    typedef struct packed {
        request_t req;
        logic     has_fixed;
        wake_t    fixed;
    } row_t;

    logic clk;
    logic rst_n;

    sdq_req_if req_ch ();
    sdq_rsp_if rsp_ch ();

    sleep_delta_queue_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    // Queue model.
    logic [sdq_pkg::TID_W-1:0]   q_thread [DEPTH];
    logic [sdq_pkg::DELTA_W-1:0] q_delta  [DEPTH];
    int                          q_count;

    wake_t wake_queue [$];
    int    mismatches;
    int    idle_cycles;
    bit    no_idle;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic predict(input request_t r);
        int rest;
        int pos;
        int n;
        wake_t w;
        begin
            if (r.cmd == sdq_pkg::CMD_SLEEP)
            begin
                rest = (r.ticks == 0) ? 1 : int'(r.ticks);
                pos  = 0;
                if (q_count >= DEPTH)
                begin
                    w.thread = r.tid;
                    w.status = sdq_pkg::STATUS_REJECT;
                    w.last   = 1'b1;
                    wake_queue.push_back(w);
                end
                else
                begin
                    while (pos < q_count && rest >= int'(q_delta[pos]))
                    begin
                        rest -= int'(q_delta[pos]);
                        pos++;
                    end
                    if (pos < q_count)
                        q_delta[pos] = q_delta[pos] - sdq_pkg::DELTA_W'(rest);
                    for (int k = q_count; k > pos; k--)
                    begin
                        q_thread[k] = q_thread[k-1];
                        q_delta[k]  = q_delta[k-1];
                    end
                    q_thread[pos] = r.tid;
                    q_delta[pos]  = sdq_pkg::DELTA_W'(rest);
                    q_count++;
                end
            end
            else if (q_count > 0)
            begin
                if (q_delta[0] > 1)
                    q_delta[0] = q_delta[0] - 1'b1;
                else
                begin
                    n = 0;
                    while (n < q_count && (n == 0 || q_delta[n] == 0))
                    begin
                        w.thread = q_thread[n];
                        w.status = sdq_pkg::STATUS_WOKEN;
                        w.last   = 1'b0;
                        wake_queue.push_back(w);
                        n++;
                    end
                    wake_queue[$].last = 1'b1;
                    for (int k = n; k < q_count; k++)
                    begin
                        q_thread[k-n] = q_thread[k];
                        q_delta[k-n]  = q_delta[k];
                    end
                    q_count -= n;
                end
            end
        end
    endtask

    // Valid stays high between back-to-back requests; it drops only for an
    // idle burst or when the caller ends a phase.
    task automatic send(input request_t r);
        begin
            if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                req_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            req_ch.valid       <= 1'b1;
            req_ch.cmd         <= r.cmd;
            req_ch.thread_id   <= r.tid;
            req_ch.sleep_ticks <= r.ticks;
            do
                @(posedge clk);
            while (!req_ch.ready);
            predict(r);
        end
    endtask

    task automatic stop_requests();
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    function automatic request_t mk(input logic c, input int t, input int d);
        request_t r;
        begin
            r.cmd   = c;
            r.tid   = sdq_pkg::TID_W'(t);
            r.ticks = sdq_pkg::DELTA_W'(d);
            return r;
        end
    endfunction

    // Result side: random stalls, compare against the oldest expectation.
    initial
    begin
        wake_t got;
        rsp_ch.ready <= 1'b0;
        mismatches = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.thread = rsp_ch.woken_thread;
                got.status = rsp_ch.status;
                got.last   = rsp_ch.last;
                if (wake_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    if (got !== wake_queue[0])
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: thread exp %0d got %0d, status exp %0b got %0b, last exp %0b got %0b",
                                wake_queue[0].thread, got.thread, wake_queue[0].status,
                                got.status, wake_queue[0].last, got.last);
                    end
                    void'(wake_queue.pop_front());
                end
            end
            if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                // Ready was low at this edge, so nothing was accepted here.
                rsp_ch.ready <= 1'b1;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles without any accepted request or result.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        row_t rows [$];
        row_t rw;
        request_t r;
        wake_t w;
        int sel;
        int sent;
        rst_n              = 1'b0;
        no_idle            = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.cmd         = sdq_pkg::CMD_SLEEP;
        req_ch.thread_id   = '0;
        req_ch.sleep_ticks = '0;
        q_count            = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Tick on an empty queue, zero and extreme sleeps, equal wake times,
        // a full queue with a typed-in reject.
        rw = '0; rw.req = mk(sdq_pkg::CMD_TICK, 0, 0); rows.push_back(rw);
        rw.req = mk(sdq_pkg::CMD_SLEEP, 8'hFF, 0); rows.push_back(rw);
        rw.req = mk(sdq_pkg::CMD_TICK, 0, 16'hFFFF); rows.push_back(rw);
        rw.req = mk(sdq_pkg::CMD_SLEEP, 1, 3); rows.push_back(rw);
        rw.req = mk(sdq_pkg::CMD_SLEEP, 2, 3); rows.push_back(rw);
        rw.req = mk(sdq_pkg::CMD_SLEEP, 3, 1); rows.push_back(rw);
        for (int i = 0; i < 4; i++)
        begin
            rw.req = mk(sdq_pkg::CMD_TICK, 0, 0); rows.push_back(rw);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            rw.req = mk(sdq_pkg::CMD_SLEEP, 16 + i, (i == 0) ? 16'hFFFF : i);
            rows.push_back(rw);
        end
        rw.req = mk(sdq_pkg::CMD_SLEEP, 8'hAA, 5);
        rw.has_fixed = 1'b1;
        rw.fixed.thread = 8'hAA;
        rw.fixed.status = sdq_pkg::STATUS_REJECT;
        rw.fixed.last = 1'b1;
        rows.push_back(rw);

        foreach (rows[i])
        begin
            if (rows[i].has_fixed && q_count >= DEPTH)
            begin
                w = rows[i].fixed;
                send(rows[i].req);
                if (wake_queue.size() == 0 || wake_queue[$] !== w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("directed row %0d: predictor disagrees with typed result", i);
                end
            end
            else
                send(rows[i].req);
        end

        // Wake every short sleeper with ticks; the long sleeper stays behind.
        while (q_count > 1)
            send(mk(sdq_pkg::CMD_TICK, 0, 0));
        stop_requests();

        // Hold off until every expected result has come.
        while (wake_queue.size() != 0)
            @(posedge clk);

        sent = 0;
        while (sent < N_RANDOM)
        begin
            if (sent > N_RANDOM * 4 / 5)
                no_idle = 1'b1;
            sel = $urandom_range(0, 9);
            r.tid = sdq_pkg::TID_W'($urandom);
            r.ticks = (sel == 0) ? sdq_pkg::DELTA_W'($urandom) :
                      (sel == 1) ? 16'h0000 : sdq_pkg::DELTA_W'($urandom_range(0, 6));
            r.cmd = ($urandom_range(0, 1) == 0) ? sdq_pkg::CMD_SLEEP : sdq_pkg::CMD_TICK;
            send(r);
            sent++;
        end
        stop_requests();

        while (wake_queue.size() != 0)
            @(posedge clk);
        repeat (4 * DEPTH + 10) @(posedge clk);

        if (mismatches == 0 && wake_queue.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
